FILE: design/erma_pkg.sv
// Shared package for the edge-replicated moving average.
// Holds default widths, window constants and the job control struct.
// Used by erma_window, erma_mean and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package erma_pkg;

  // Default sample width in bits.
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Number of past samples kept, and the saturation value of the sample count.
  localparam int HIST_DEPTH = 4;
  localparam int SEEN_MAX   = 4;

  // Window sizes and half widths.
  localparam int TAPS_NARROW = 3;
  localparam int TAPS_WIDE   = 5;
  localparam int HALF_NARROW = 1;
  localparam int HALF_WIDE   = 2;
  localparam int TAP_SLOTS   = TAPS_WIDE;

  // Control that travels with one window sum into the divider.
  typedef struct packed {
    logic wide;  // window was five taps wide
    logic last;  // final result of the sequence
  } job_ctl_t;

endpackage

`default_nettype wire

FILE: design/edge_replicated_moving_average.sv
// Edge-replicated centered moving average, top level.
// Instantiates erma_window and erma_mean; depends on erma_pkg.
`timescale 1ns / 1ps
`default_nettype none

// This block averages a stream of signed samples over a centered window of
// three taps (cfg_wr_data = 0, the reset value) or five taps (1). Where the
// window reaches past either end of a sequence, the first or last sample
// stands in for the missing neighbors. Each result is the window sum divided
// by the tap count, rounded to nearest with ties toward positive infinity.
// Results lag the samples by half a window: a result for a sample appears
// once the sample one or two positions later has been taken. The sample that
// carries in_last_sample flushes the remaining results of its sequence (up
// to three for the wide window), marks the final one with out_last_result,
// and starts a fresh sequence. Both channels use a valid/stall handshake; a
// request moves on a rising edge where valid is high and stall is low.
// Throughput is one sample per clock while neither a closing sample nor a
// stalled receiver holds the flow. A closing sample occupies the window
// stage until it has released all its results; in_stall is high throughout
// but for the last release, in which the next request can already be taken.
// The window stage forms one window sum per cycle while the divider takes
// them; three register stages follow (the sum, the reciprocal product, the
// corrected quotient in the output register), and each result passes
// through them in that order. Write the configuration only while the block
// is idle.

module edge_replicated_moving_average #(
  parameter int SAMPLE_WIDTH = erma_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                           in_last_sample,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_average,
  output logic                                out_last_result
);

  // One window request from the sequencer to the divider pipeline.
  logic                           job_valid;
  logic                           job_ready;
  logic signed [SAMPLE_WIDTH+2:0] job_sum;
  erma_pkg::job_ctl_t             job_ctl;

  // The window stage keeps the history, decides how many results each sample
  // releases, and sums one window's taps per cycle unless the divider stalls.
  erma_window #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_sample         (in_sample),
    .in_last_sample    (in_last_sample),
    .in_stall          (in_stall),
    .job_valid         (job_valid),
    .job_ready         (job_ready),
    .job_sum           (job_sum),
    .job_ctl           (job_ctl)
  );

  // The divider pipeline turns each sum into the rounded mean; its last stage
  // is the output register, which holds a result while the receiver stalls.
  erma_mean #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mean (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (job_valid),
    .job_ready       (job_ready),
    .job_sum         (job_sum),
    .job_ctl         (job_ctl),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_average     (out_average),
    .out_last_result (out_last_result)
  );

endmodule

`default_nettype wire

FILE: design/erma_window.sv
// Window stage of the edge-replicated moving average: configuration register,
// sample history, result sequencing and the window tap sum.
// Depends on erma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erma_window #(
  parameter int SAMPLE_WIDTH = erma_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_wr_data,
  input  wire logic                           in_valid,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                           in_last_sample,
  output logic                                in_stall,
  output logic                                job_valid,
  input  wire logic                           job_ready,
  output logic signed [SAMPLE_WIDTH+2:0]      job_sum,
  output erma_pkg::job_ctl_t                  job_ctl
);

  localparam int N  = SAMPLE_WIDTH;
  localparam int TW = N + 3;

  logic                 wide_r;
  logic [N-1:0]         cur_r;
  logic [N-1:0]         hist_r [erma_pkg::HIST_DEPTH];
  logic [2:0]           seen_r;
  logic                 last_r;
  logic                 pend_r;
  logic [1:0]           ctr_r;

  logic [2:0]           seen_nxt;
  logic [2:0]           half;
  logic                 accept;
  logic                 fire;
  logic                 done;
  logic signed [3:0]    tap_back [erma_pkg::TAP_SLOTS];
  logic [N-1:0]         tapv [erma_pkg::TAP_SLOTS];
  logic [erma_pkg::TAP_SLOTS-1:0] tap_en;
  logic signed [TW-1:0] sum;

  assign half = wide_r ? 3'(erma_pkg::HALF_WIDE) : 3'(erma_pkg::HALF_NARROW);

  // The held item's pre-update history becomes the next item's history.
  always_comb begin
    if (last_r) begin
      seen_nxt = '0;
    end else if (seen_r == 3'(erma_pkg::SEEN_MAX)) begin
      seen_nxt = seen_r;
    end else begin
      seen_nxt = seen_r + 3'd1;
    end
  end

  assign fire     = pend_r & job_ready;
  assign done     = fire & (~last_r | (ctr_r == 2'd0));
  assign in_stall = pend_r & ~done;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
    end else if (cfg_wr_en) begin
      wide_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      last_r <= 1'b1;
      pend_r <= 1'b0;
      ctr_r  <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
      last_r <= in_last_sample;
      pend_r <= in_last_sample | (seen_nxt >= half);
      if (in_last_sample && (seen_nxt < half)) begin
        ctr_r <= seen_nxt[1:0];
      end else begin
        ctr_r <= half[1:0];
      end
    end else if (fire) begin
      if (done) begin
        pend_r <= 1'b0;
      end else begin
        ctr_r <= ctr_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r     <= in_sample;
      hist_r[0] <= cur_r;
      for (int i = 1; i < erma_pkg::HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // Tap slot j looks (center - (j - 2)) samples back, clamped to the first
  // sample of the sequence and to the current sample.
  always_comb begin
    sum = '0;
    for (int j = 0; j < erma_pkg::TAP_SLOTS; j++) begin
      tap_back[j] = $signed(4'(ctr_r) + 4'd2 - 4'(j));
      if (tap_back[j] < 4'sd0) begin
        tap_back[j] = 4'sd0;
      end else if (tap_back[j] > $signed({1'b0, seen_r})) begin
        tap_back[j] = $signed({1'b0, seen_r});
      end
      if (tap_back[j] == 4'sd0) begin
        tapv[j] = cur_r;
      end else begin
        tapv[j] = hist_r[2'(tap_back[j] - 4'sd1)];
      end
      tap_en[j] = wide_r | ((j >= 1) && (j <= 3));
      if (tap_en[j]) begin
        sum = sum + TW'($signed(tapv[j]));
      end
    end
  end

  assign job_valid    = pend_r;
  assign job_sum      = sum;
  assign job_ctl.wide = wide_r;
  assign job_ctl.last = last_r & (ctr_r == 2'd0);

endmodule

`default_nettype wire

FILE: design/erma_mean.sv
// Divider pipeline of the edge-replicated moving average: turns a window sum
// into the rounded mean by a reciprocal multiply with one correction step.
// Depends on erma_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erma_mean #(
  parameter int SAMPLE_WIDTH = erma_pkg::DEF_SAMPLE_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          job_valid,
  output logic                               job_ready,
  input  wire logic signed [SAMPLE_WIDTH+2:0] job_sum,
  input  wire erma_pkg::job_ctl_t            job_ctl,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]     out_average,
  output logic                               out_last_result
);

  localparam int N  = SAMPLE_WIDTH;
  localparam int TW = N + 3;
  localparam int MW = N + 2;
  localparam int PW = TW + MW;

  // floor(2^TW / W): the estimate is exact or one low for any offset sum.
  localparam logic [MW-1:0] RECIP_NARROW =
      MW'((64'd1 << TW) / 64'(erma_pkg::TAPS_NARROW));
  localparam logic [MW-1:0] RECIP_WIDE =
      MW'((64'd1 << TW) / 64'(erma_pkg::TAPS_WIDE));

  // Rounding bias (W-1)/2 plus W * 2^(N-1), which makes the dividend positive.
  localparam logic [TW-1:0] OFS_NARROW =
      TW'(64'(erma_pkg::TAPS_NARROW) * (64'd1 << (N - 1)) + 64'd1);
  localparam logic [TW-1:0] OFS_WIDE =
      TW'(64'(erma_pkg::TAPS_WIDE) * (64'd1 << (N - 1)) + 64'd2);

  logic                 s1_v_r;
  logic signed [TW-1:0] s1_sum_r;
  erma_pkg::job_ctl_t   s1_ctl_r;
  logic                 s2_v_r;
  logic [TW-1:0]        s2_t_r;
  logic [N-1:0]         s2_qe_r;
  erma_pkg::job_ctl_t   s2_ctl_r;
  logic                 s3_v_r;
  logic [N-1:0]         s3_avg_r;
  logic                 s3_last_r;

  logic                 s1_ready;
  logic                 s2_ready;
  logic                 s3_ready;
  logic [TW-1:0]        t_val;
  logic [MW-1:0]        recip;
  logic [PW-1:0]        prod;
  logic [TW-1:0]        qe_ext;
  logic [TW-1:0]        wq;
  logic [TW-1:0]        rem;
  logic                 bump;
  logic [N-1:0]         q_val;

  assign s3_ready  = ~s3_v_r | ~out_stall;
  assign s2_ready  = ~s2_v_r | s3_ready;
  assign s1_ready  = ~s1_v_r | s2_ready;
  assign job_ready = s1_ready;

  assign t_val = $unsigned(s1_sum_r) + (s1_ctl_r.wide ? OFS_WIDE : OFS_NARROW);
  assign recip = s1_ctl_r.wide ? RECIP_WIDE : RECIP_NARROW;
  assign prod  = PW'(t_val) * PW'(recip);

  // Remainder check: W * q_est is a shift and an add.
  assign qe_ext = TW'(s2_qe_r);
  assign wq     = s2_ctl_r.wide ? (qe_ext + (qe_ext << 2)) : (qe_ext + (qe_ext << 1));
  assign rem    = s2_t_r - wq;
  assign bump   = s2_ctl_r.wide ? (rem >= TW'(erma_pkg::TAPS_WIDE))
                                : (rem >= TW'(erma_pkg::TAPS_NARROW));
  assign q_val  = s2_qe_r + N'(bump);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= job_valid;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_ready) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && job_valid) begin
      s1_sum_r <= job_sum;
      s1_ctl_r <= job_ctl;
    end
    if (s2_ready && s1_v_r) begin
      s2_t_r   <= t_val;
      s2_qe_r  <= prod[TW +: N];
      s2_ctl_r <= s1_ctl_r;
    end
    if (s3_ready && s2_v_r) begin
      // Removing the 2^(N-1) offset is a flip of the top bit.
      s3_avg_r  <= {~q_val[N-1], q_val[N-2:0]};
      s3_last_r <= s2_ctl_r.last;
    end
  end

  assign out_valid       = s3_v_r;
  assign out_average     = $signed(s3_avg_r);
  assign out_last_result = s3_last_r;

endmodule

`default_nettype wire
